// ===== rtl/life_automaton_torus_macros.svh =====
// Assertion macros used by the life automaton RTL.
`ifndef LIFE_AUTOMATON_TORUS_MACROS_SVH
`define LIFE_AUTOMATON_TORUS_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define LAT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside of reset.
`define LAT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/lat_pkg.sv =====
// Package of the life automaton: widths, command codes, cell control and helpers.
package lat_pkg;

  localparam int unsigned ROWS_DEF = 32;
  localparam int unsigned COLS_DEF = 64;
  localparam int unsigned MAX_COLS = 64;

  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 6;
  localparam int unsigned LIVE_W = 12;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned IN_W   = 16;
  localparam int unsigned OUT_W  = 16;
  localparam int unsigned PC_W   = 7;

  localparam logic [LIVE_W-1:0] LIVE_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic             shift;
    logic             wr_en;
    logic             wr_val;
    logic             in_range;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cell_ctrl_t;

  // Population count as a pairwise adder tree.
  function automatic logic [PC_W-1:0] popcnt(input logic [MAX_COLS-1:0] w);
    logic [PC_W-1:0] s [MAX_COLS];
    for (int i = 0; i < MAX_COLS; i++) begin
      s[i] = PC_W'(w[i]);
    end
    for (int st = 1; st < MAX_COLS; st = st * 2) begin
      for (int i = 0; i < MAX_COLS; i = i + 2 * st) begin
        s[i] = s[i] + s[i+st];
      end
    end
    return s[0];
  endfunction

endpackage

// ===== rtl/lat_cell.sv =====
// One row cell of the ring: holds a grid row, shifts toward its neighbor, serves accesses.
module lat_cell #(
  parameter int unsigned COLS = lat_pkg::COLS_DEF,
  parameter int unsigned IDX  = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lat_pkg::cell_ctrl_t ctrl_i,
  input  logic [COLS-1:0]     shift_i,
  output logic [COLS-1:0]     row_o,
  output logic                bit_o
);

  localparam int unsigned CIW = $clog2(COLS);

  logic [COLS-1:0] row_q, row_d;
  logic            hit;
  logic [CIW-1:0]  cidx;

  assign cidx = ctrl_i.col[CIW-1:0];
  assign hit  = ctrl_i.in_range && (32'(ctrl_i.row) == IDX);

  always_comb begin
    row_d = row_q;
    if (ctrl_i.shift) begin
      row_d = shift_i;
    end else if (hit && ctrl_i.wr_en) begin
      row_d[cidx] = ctrl_i.wr_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;
  assign bit_o = hit & row_q[cidx];

endmodule

// ===== rtl/lat_rule.sv =====
// Next-generation rule for one row from its old row and its two wrapped neighbor rows.
module lat_rule #(
  parameter int unsigned COLS = lat_pkg::COLS_DEF
) (
  input  logic [COLS-1:0] up_i,
  input  logic [COLS-1:0] mid_i,
  input  logic [COLS-1:0] dn_i,
  output logic [COLS-1:0] nxt_o
);

  logic [COLS-1:0] ul, ur, ml, mr, dl, dr;

  // bit c of *l holds column c-1, bit c of *r holds column c+1, both wrapped
  assign ul = {up_i[COLS-2:0], up_i[COLS-1]};
  assign ur = {up_i[0], up_i[COLS-1:1]};
  assign ml = {mid_i[COLS-2:0], mid_i[COLS-1]};
  assign mr = {mid_i[0], mid_i[COLS-1:1]};
  assign dl = {dn_i[COLS-2:0], dn_i[COLS-1]};
  assign dr = {dn_i[0], dn_i[COLS-1:1]};

  always_comb begin
    for (int c = 0; c < COLS; c++) begin : g_col
      logic [3:0] nb;
      nb = 4'(ul[c]) + 4'(up_i[c]) + 4'(ur[c]) + 4'(ml[c]) + 4'(mr[c])
         + 4'(dl[c]) + 4'(dn_i[c]) + 4'(dr[c]);
      if (nb == 4'd2) begin
        nxt_o[c] = mid_i[c];
      end else if (nb == 4'd3) begin
        nxt_o[c] = 1'b1;
      end else begin
        nxt_o[c] = 1'b0;
      end
    end
  end

endmodule

// ===== rtl/life_automaton_torus.sv =====
// Top level of the toroidal life automaton: ring of row cells, sequencer, result buffer.
//
//  channel | dir | tdata (low bit up)                   | tuser
//  s_axis  | in  | row[4:0] col[10:5] value[11] 0[15:12] | cmd[1:0]
//  m_axis  | out | cell_value[0] live_count[12:1] 0[15:13] | -
//
// Write, read and unused commands give their result as they are taken; a generation step
// accepts the request, rotates the ring in ST_STEP, moving each row cell past the
// rule logic, and counts the last new row in ST_FIN.
// Reset clears every cell and the population at once; no clearing pass.
// Results sit in an output register with a one-entry skid; requests are taken
// while a result waits, and tready drops only during a step or with the skid full.
`include "life_automaton_torus_macros.svh"

module life_automaton_torus #(
  parameter int unsigned ROWS = lat_pkg::ROWS_DEF,
  parameter int unsigned COLS = lat_pkg::COLS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [lat_pkg::IN_W-1:0]   s_axis_tdata,   // row, col, value
  input  logic [lat_pkg::CMD_W-1:0]  s_axis_tuser,   // cmd
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [lat_pkg::OUT_W-1:0]  m_axis_tdata    // cell_value, live_count
);

  localparam int unsigned RIW   = $clog2(ROWS);
  localparam int unsigned CNT_W = $clog2(ROWS * COLS + 1);
  localparam int unsigned MW    = lat_pkg::MAX_COLS;
  localparam int unsigned LW    = lat_pkg::LIVE_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_STEP = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e                     state_q, state_d;
  logic [RIW-1:0]             k_q, k_d;
  logic [CNT_W-1:0]           pop_q, pop_d;
  logic [COLS-1:0]            prev_q, first_q;
  logic                       out_vld_q, skid_vld_q;
  logic [lat_pkg::OUT_W-1:0]  out_q, skid_q;

  logic                       acc, in_range, old_bit, res_vld, res_cell;
  logic [lat_pkg::ROW_W-1:0]  s_row;
  logic [lat_pkg::COL_W-1:0]  s_col;
  logic                       s_val;
  lat_pkg::cmd_e              cmd;
  lat_pkg::cell_ctrl_t        ctrl;
  logic [COLS-1:0]            rows_w [ROWS];
  logic [ROWS-1:0]            bits_w;
  logic [COLS-1:0]            up_w, dn_w, nxt_w;
  logic [lat_pkg::PC_W-1:0]   pc;
  logic [LW-1:0]              live;
  logic [lat_pkg::OUT_W-1:0]  res;
  logic                       last_row;

  assign s_row = s_axis_tdata[4:0];
  assign s_col = s_axis_tdata[10:5];
  assign s_val = s_axis_tdata[11];
  assign cmd   = lat_pkg::cmd_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == ST_IDLE) && !skid_vld_q;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign in_range      = (32'(s_row) < ROWS) && (32'(s_col) < COLS);
  assign last_row      = (k_q == RIW'(ROWS - 1));

  assign ctrl.shift    = (state_q == ST_STEP);
  assign ctrl.wr_en    = acc && (cmd == lat_pkg::CMD_WRITE);
  assign ctrl.wr_val   = s_val;
  assign ctrl.in_range = in_range;
  assign ctrl.row      = s_row;
  assign ctrl.col      = s_col;

  for (genvar i = 0; i < ROWS; i++) begin : g_cell
    logic [COLS-1:0] sh;
    if (i < ROWS - 1) begin : g_mid
      assign sh = rows_w[i+1];
    end else begin : g_tail
      assign sh = nxt_w;
    end
    lat_cell #(
      .COLS (COLS),
      .IDX  (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .shift_i (sh),
      .row_o   (rows_w[i]),
      .bit_o   (bits_w[i])
    );
  end

  assign old_bit = |bits_w;

  // row k sits in cell 0; upper neighbor comes from the saved old row (for row 0, from the last cell),
  // lower neighbor of the last row is the saved old first row
  assign up_w = (k_q == '0) ? rows_w[ROWS-1] : prev_q;
  assign dn_w = last_row ? first_q : rows_w[1];

  lat_rule #(
    .COLS (COLS)
  ) u_rule (
    .up_i  (up_w),
    .mid_i (rows_w[0]),
    .dn_i  (dn_w),
    .nxt_o (nxt_w)
  );

  assign pc = lat_pkg::popcnt(MW'(rows_w[ROWS-1]));

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    pop_d    = pop_q;
    res_vld  = 1'b0;
    res_cell = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          unique case (cmd)
            lat_pkg::CMD_WRITE: begin
              res_vld = 1'b1;
              if (in_range && (s_val != old_bit)) begin
                pop_d = s_val ? pop_q + CNT_W'(1) : pop_q - CNT_W'(1);
              end
            end
            lat_pkg::CMD_STEP: begin
              pop_d   = '0;
              k_d     = '0;
              state_d = ST_STEP;
            end
            lat_pkg::CMD_READ: begin
              res_vld  = 1'b1;
              res_cell = in_range & old_bit;
            end
            default: begin
              res_vld = 1'b1;
            end
          endcase
        end
      end
      ST_STEP: begin
        if (k_q != '0) begin
          pop_d = pop_q + CNT_W'(pc);
        end
        k_d = k_q + RIW'(1);
        if (last_row) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        pop_d   = pop_q + CNT_W'(pc);
        res_vld = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign live = (32'(pop_d) > 32'(lat_pkg::LIVE_MAX)) ? lat_pkg::LIVE_MAX : LW'(pop_d);
  assign res  = {3'b000, live, res_cell};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      k_q        <= '0;
      pop_q      <= '0;
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      pop_q   <= pop_d;
      if (!out_vld_q || m_axis_tready) begin
        out_vld_q  <= skid_vld_q || res_vld;
        skid_vld_q <= 1'b0;
      end else if (res_vld) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_STEP) begin
      prev_q <= rows_w[0];
      if (k_q == '0) begin
        first_q <= rows_w[0];
      end
    end
    if (!out_vld_q || m_axis_tready) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (res_vld) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  `LAT_NEVER(a_res_skid_full, clk_i, rst_ni, res_vld && skid_vld_q, "result lost: skid full")
  `LAT_ASSERT(a_step_end, clk_i, rst_ni, (state_q == ST_STEP) && last_row |=> state_q == ST_FIN, "step overran")
  `LAT_ASSERT(a_fin_out, clk_i, rst_ni, state_q == ST_FIN |=> m_axis_tvalid, "step result missing")
  `LAT_ASSERT(a_pop_bound, clk_i, rst_ni, 32'(pop_q) <= 32'(ROWS * COLS), "population above grid size")

endmodule

// ===== sim/life_grid_checker.sv =====
// Checker for the life automaton: watches both streams, predicts each result and compares.
module life_grid_checker
  import lat_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // row, col, value
  input  logic [CMD_W-1:0]  s_axis_tuser,   // cmd
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [OUT_W-1:0]  m_axis_tdata,   // cell_value, live_count
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o,
  output int                peak_live_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = ROWS_DEF;
  localparam int COLS = COLS_DEF;

  typedef struct packed {
    logic [LIVE_W-1:0] live;
    logic              cell_bit;
  } outcome_t;

  logic [COLS-1:0]   grid_q [ROWS];
  logic [LIVE_W-1:0] live_cells;
  outcome_t          expected_q [$];

  task automatic report(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  function automatic int neighbors(input int r, input int c);
    int n;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr != 0 || dc != 0) begin
          n += int'(grid_q[(r + dr + ROWS) % ROWS][(c + dc + COLS) % COLS]);
        end
      end
    end
    return n;
  endfunction

  function automatic void next_generation();
    logic [COLS-1:0] fresh [ROWS];
    int n;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        n = neighbors(r, c);
        fresh[r][c] = (n == 3) || (n == 2 && grid_q[r][c]);
      end
    end
    for (int r = 0; r < ROWS; r++) begin
      grid_q[r] = fresh[r];
    end
  endfunction

  function automatic void recount();
    int total;
    total = 0;
    for (int r = 0; r < ROWS; r++) begin
      total += $countones(grid_q[r]);
    end
    live_cells = (total > int'(LIVE_MAX)) ? LIVE_MAX : LIVE_W'(total);
  endfunction

  function automatic outcome_t apply_request(input logic [CMD_W-1:0] cmd,
                                             input logic [IN_W-1:0] data);
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             value;
    logic             hit;
    outcome_t         o;
    row   = data[ROW_W-1:0];
    col   = data[ROW_W +: COL_W];
    value = data[ROW_W+COL_W];
    hit   = (int'(row) < ROWS) && (int'(col) < COLS);
    o.cell_bit = 1'b0;
    case (cmd)
      CMD_WRITE: begin
        if (hit) begin
          grid_q[row][col] = value;
          recount();
        end
      end
      CMD_STEP: begin
        next_generation();
        recount();
      end
      CMD_READ: begin
        if (hit) o.cell_bit = grid_q[row][col];
      end
      default: ;
    endcase
    o.live = live_cells;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t want;
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) grid_q[r] = '0;
      live_cells = '0;
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report("result with no request waiting", int'(m_axis_tdata), -1);
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          if (m_axis_tdata[0] !== want.cell_bit)
            report("cell_value", int'(m_axis_tdata[0]), int'(want.cell_bit));
          if (m_axis_tdata[LIVE_W:1] !== want.live)
            report("live_count", int'(m_axis_tdata[LIVE_W:1]), int'(want.live));
          if (m_axis_tdata[OUT_W-1:LIVE_W+1] !== '0)
            report("tdata padding", int'(m_axis_tdata[OUT_W-1:LIVE_W+1]), 0);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(apply_request(s_axis_tuser, s_axis_tdata));
        if (int'(live_cells) > peak_live_o) peak_live_o = int'(live_cells);
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== sim/life_automaton_torus_tb.sv =====
// Testbench top for the life automaton: clock, reset, request stimulus and verdict.
module life_automaton_torus_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lat_pkg::*;

  localparam int ROWS = ROWS_DEF;
  localparam int COLS = COLS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = ROWS + 8;
  localparam int MAX_GAP      = 13;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0] s_axis_tuser = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  logic        steady = 1'b0;
  int unsigned sink_wait = 0;
  int          cycles = 0;
  int          sent = 0;
  int          n_write = 0, n_step = 0, n_read = 0, n_unused = 0;
  int          fail_count, pending, checked, peak_live;

  life_automaton_torus #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  life_grid_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .peak_live_o  (peak_live)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding", pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result sink: random stall after each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin : sink
    int unsigned hold;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= 0;
    end else if (m_axis_tready) begin
      if (m_axis_tvalid) begin
        hold = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (hold != 0) begin
          m_axis_tready <= 1'b0;
          sink_wait     <= hold;
        end
      end
    end else if (sink_wait <= 1) begin
      m_axis_tready <= 1'b1;
    end else begin
      sink_wait <= sink_wait - 1;
    end
  end

  task automatic send_request(input logic [CMD_W-1:0] cmd, input int r, input int c,
                              input logic v);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_W-ROW_W-COL_W-1){1'b0}}, v, COL_W'(c), ROW_W'(r)};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    case (cmd)
      CMD_WRITE: n_write++;
      CMD_STEP:  n_step++;
      CMD_READ:  n_read++;
      default:   n_unused++;
    endcase
  endtask

  task automatic put_cell(input int r, input int c, input logic v);
    send_request(CMD_WRITE, r % ROWS, c % COLS, v);
  endtask

  task automatic peek_cell(input int r, input int c);
    send_request(CMD_READ, r % ROWS, c % COLS, logic'($urandom_range(0, 1)));
  endtask

  // address fields are don't-care for a generation step
  task automatic advance_grid();
    send_request(CMD_STEP, $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                 logic'($urandom_range(0, 1)));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int directed;
    int br, bc, pick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners are mutual neighbors across the wrap
    put_cell(0, 0, 1'b1);
    put_cell(ROWS - 1, COLS - 1, 1'b1);
    put_cell(0, COLS - 1, 1'b1);
    put_cell(ROWS - 1, 0, 1'b1);
    peek_cell(ROWS - 1, COLS - 1);
    send_request(CMD_UNUSED, ROWS - 1, COLS - 1, 1'b1);
    advance_grid();
    peek_cell(0, 0);
    put_cell(0, 0, 1'b0);
    peek_cell(0, 0);
    advance_grid();
    // blinker: birth on three, death on isolation
    put_cell(15, 30, 1'b1);
    put_cell(15, 31, 1'b1);
    put_cell(15, 32, 1'b1);
    advance_grid();
    peek_cell(14, 31);
    peek_cell(15, 30);
    advance_grid();
    peek_cell(15, 30);
    wait_idle();
    directed = sent;

    while (sent - directed < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 99);
      br = $urandom_range(0, ROWS - 1);
      bc = $urandom_range(0, COLS - 1);
      if (pick < 50) begin
        case ($urandom_range(0, 3))
          0: begin
            put_cell(br, bc + 1, 1'b1);
            put_cell(br + 1, bc + 2, 1'b1);
            put_cell(br + 2, bc, 1'b1);
            put_cell(br + 2, bc + 1, 1'b1);
            put_cell(br + 2, bc + 2, 1'b1);
          end
          1: begin
            for (int i = 0; i < 3; i++) put_cell(br, bc + i, 1'b1);
          end
          2: begin
            for (int i = 0; i < 4; i++) put_cell(br + i / 2, bc + i % 2, 1'b1);
          end
          default: begin
            for (int i = 0; i < 16; i++)
              if ($urandom_range(0, 1) != 0) put_cell(br + i / 4, bc + i % 4, 1'b1);
          end
        endcase
        repeat ($urandom_range(1, 6)) begin
          advance_grid();
          repeat ($urandom_range(0, 3))
            peek_cell(br + $urandom_range(0, 4), bc + $urandom_range(0, 4));
        end
      end else if (pick < 65) begin
        repeat ($urandom_range(10, 25))
          put_cell(br + $urandom_range(0, 7), bc + $urandom_range(0, 7),
                   logic'($urandom_range(0, 4) < 3));
        repeat ($urandom_range(2, 6)) begin
          advance_grid();
          repeat ($urandom_range(1, 3))
            peek_cell(br + $urandom_range(0, 7), bc + $urandom_range(0, 7));
        end
      end else if (pick < 75) begin
        repeat ($urandom_range(4, 10)) begin
          put_cell(br + $urandom_range(0, 7), bc + $urandom_range(0, 7), 1'b0);
          peek_cell(br + $urandom_range(0, 7), bc + $urandom_range(0, 7));
        end
      end else if (pick < 93) begin
        repeat ($urandom_range(3, 8))
          send_request(CMD_W'($urandom_range(0, 3)), $urandom_range(0, (1 << ROW_W) - 1),
                       $urandom_range(0, (1 << COL_W) - 1), logic'($urandom_range(0, 1)));
      end else begin
        wait_idle();
      end
    end

    steady = 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d requests: %0d writes, %0d generation steps, %0d reads, %0d unused.",
             sent, n_write, n_step, n_read, n_unused);
    $display("Checked %0d results, peak population %0d, %0d mismatches.",
             checked, peak_live, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
